// File: hw/rtl/sxt_pkg.sv
// Shared types and character constants for the S-expression tokenizer.
package sxt_pkg;

  typedef enum logic [3:0] {
    KIND_SYMBOL     = 4'd0,
    KIND_STRING     = 4'd1,
    KIND_LPAR       = 4'd2,
    KIND_RPAR       = 4'd3,
    KIND_QUOTE      = 4'd4,
    KIND_SHARP      = 4'd5,
    KIND_QUASIQUOTE = 4'd6,
    KIND_UNQUOTE    = 4'd7,
    KIND_SEMICOLON  = 4'd8,
    KIND_REF        = 4'd9,
    KIND_KEYWORD    = 4'd10
  } kind_e;

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_SYM  = 6'b000010,
    MODE_STR  = 6'b000100,
    MODE_ESC  = 6'b001000,
    MODE_HEX1 = 6'b010000,
    MODE_HEX2 = 6'b100000
  } mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_value;
    logic       has_char;
    logic       token_start;
    logic       token_end;
    logic       last_of_run;
  } result_t;

  localparam logic [7:0] CH_LPAR    = 8'h28;
  localparam logic [7:0] CH_RPAR    = 8'h29;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SHARP   = 8'h23;
  localparam logic [7:0] CH_BTICK   = 8'h60;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_B   = 8'h62;
  localparam logic [7:0] CH_LOW_T   = 8'h74;
  localparam logic [7:0] CH_LOW_V   = 8'h76;
  localparam logic [7:0] CH_LOW_N   = 8'h6E;
  localparam logic [7:0] CH_LOW_R   = 8'h72;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_GRAPH_LO = 8'h21;
  localparam logic [7:0] CH_GRAPH_HI = 8'h7E;

  localparam logic [7:0] CASE_OFFSET = 8'd32;
  // 'a' - 10: letters a..f map to 10..15
  localparam logic [7:0] HEX_ALPHA_BIAS = 8'd87;

endpackage

// File: hw/rtl/sxt_in_if.sv
// Input channel: one source byte or an end-of-input mark per transaction.
interface sxt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// File: hw/rtl/sxt_out_if.sv
// Output channel: one token result per transaction.
interface sxt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] char_value;
  logic       has_char;
  logic       token_start;
  logic       token_end;
  logic       last_of_run;

  modport source (output valid, output token_kind, output char_value, output has_char,
                  output token_start, output token_end, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input char_value, input has_char,
                  input token_start, input token_end, input last_of_run, output ready);
endinterface

// File: hw/rtl/sexpr_tokenizer.sv
// Top level of the S-expression tokenizer: lexer state machine and result queue.
//
//   channel | dir | transaction moves
//   --------+-----+-----------------------------------------------------------
//   in_i    | in  | one source byte, or an end-of-input mark
//   out_o   | out | one token result (kind, char, start/end flags, last flag)
//
// Timing: one byte per cycle while out_o keeps up; its zero, one or two results
//   are written into the registered queue at the accepting edge and offered on out_o from there.
// Rate: a byte is taken only while two of the four queue entries are free. A symbol
//   closed by punctuation gives two results, so short symbols back to back outrun
//   the one-result-per-cycle output and hold intake now and then.
// Reset: asynchronous, active low; clears the lexer mode to idle, the hex
//   accumulator and the queue pointers.
// Stalls: out_o.ready low holds the queue head; in_i.ready drops once fewer
//   than two entries are free.
module sexpr_tokenizer (
  input  logic            clk_i,
  input  logic            rst_ni,
  sxt_in_if.sink          in_i,
  sxt_out_if.source       out_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  // ---------------------------------------------------------------------------
  // Character helpers
  // ---------------------------------------------------------------------------
  function automatic logic is_graphic(logic [7:0] b);
    return b inside {[sxt_pkg::CH_GRAPH_LO:sxt_pkg::CH_GRAPH_HI]};
  endfunction

  function automatic logic is_breaker(logic [7:0] b);
    return b inside {sxt_pkg::CH_LPAR, sxt_pkg::CH_RPAR, sxt_pkg::CH_QUOTE,
                     sxt_pkg::CH_DQUOTE, sxt_pkg::CH_SHARP, sxt_pkg::CH_BTICK,
                     sxt_pkg::CH_COMMA, sxt_pkg::CH_SEMI, sxt_pkg::CH_COLON};
  endfunction

  // Any byte is taken as a digit: non-decimal bytes are biased by 'a'-10, upper-case letters lowered first.
  function automatic logic [7:0] hex_val(logic [7:0] b);
    logic [7:0] low;
    low = b;
    if (b inside {[sxt_pkg::CH_DIGIT_0:sxt_pkg::CH_DIGIT_9]}) begin
      return b - sxt_pkg::CH_DIGIT_0;
    end
    if (b inside {[sxt_pkg::CH_UP_A:sxt_pkg::CH_UP_Z]}) begin
      low = b + sxt_pkg::CASE_OFFSET;
    end
    return low - sxt_pkg::HEX_ALPHA_BIAS;
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] b);
    logic [7:0] r;
    case (b)
      sxt_pkg::CH_LOW_A: r = 8'd7;
      sxt_pkg::CH_LOW_B: r = 8'd8;
      sxt_pkg::CH_LOW_T: r = 8'd9;
      sxt_pkg::CH_LOW_V: r = 8'd11;
      sxt_pkg::CH_LOW_N: r = 8'd10;
      sxt_pkg::CH_LOW_R: r = 8'd13;
      default:           r = b;
    endcase
    return r;
  endfunction

  function automatic sxt_pkg::result_t make_res(sxt_pkg::kind_e kind, logic [7:0] ch,
                                                logic has, logic st, logic en);
    sxt_pkg::result_t r;
    r.kind        = kind;
    r.char_value  = ch;
    r.has_char    = has;
    r.token_start = st;
    r.token_end   = en;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Lexer state
  // ---------------------------------------------------------------------------
  sxt_pkg::mode_e   mode_q, mode_d;
  logic [7:0]       hex_q, hex_d;

  logic             in_acc;
  logic [7:0]       b;
  logic             eoi;

  // What a byte does when seen from idle mode
  logic             idle_v;
  sxt_pkg::result_t idle_r;
  sxt_pkg::mode_e   idle_m;

  logic             v0, v1;
  sxt_pkg::result_t r0, r1;

  assign b      = in_i.in_byte;
  assign eoi    = in_i.end_of_input;
  assign in_acc = in_i.valid & in_i.ready;

  always_comb begin
    idle_v = 1'b1;
    idle_m = sxt_pkg::MODE_IDLE;
    idle_r = make_res(sxt_pkg::KIND_SYMBOL, b, 1'b1, 1'b1, 1'b1);
    case (b)
      sxt_pkg::CH_LPAR:   idle_r.kind = sxt_pkg::KIND_LPAR;
      sxt_pkg::CH_RPAR:   idle_r.kind = sxt_pkg::KIND_RPAR;
      sxt_pkg::CH_QUOTE:  idle_r.kind = sxt_pkg::KIND_QUOTE;
      sxt_pkg::CH_SHARP:  idle_r.kind = sxt_pkg::KIND_SHARP;
      sxt_pkg::CH_BTICK:  idle_r.kind = sxt_pkg::KIND_QUASIQUOTE;
      sxt_pkg::CH_COMMA:  idle_r.kind = sxt_pkg::KIND_UNQUOTE;
      sxt_pkg::CH_SEMI:   idle_r.kind = sxt_pkg::KIND_SEMICOLON;
      sxt_pkg::CH_AMP:    idle_r.kind = sxt_pkg::KIND_REF;
      sxt_pkg::CH_COLON:  idle_r.kind = sxt_pkg::KIND_KEYWORD;
      sxt_pkg::CH_DQUOTE: begin
        // open a string: start marker with no character
        idle_r = make_res(sxt_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b0);
        idle_m = sxt_pkg::MODE_STR;
      end
      default: begin
        if (is_graphic(b)) begin
          // first character of a symbol
          idle_r = make_res(sxt_pkg::KIND_SYMBOL, b, 1'b1, 1'b1, 1'b0);
          idle_m = sxt_pkg::MODE_SYM;
        end else begin
          // whitespace and non-graphic bytes: drop
          idle_v = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    hex_d  = hex_q;
    v0     = 1'b0;
    v1     = 1'b0;
    r0     = make_res(sxt_pkg::KIND_SYMBOL, 8'd0, 1'b0, 1'b0, 1'b0);
    r1     = r0;

    if (eoi) begin
      // close whatever is open; a partial escape is dropped
      mode_d = sxt_pkg::MODE_IDLE;
      hex_d  = 8'd0;
      if (mode_q == sxt_pkg::MODE_SYM) begin
        v0 = 1'b1;
        r0 = make_res(sxt_pkg::KIND_SYMBOL, 8'd0, 1'b0, 1'b0, 1'b1);
      end else if (mode_q inside {sxt_pkg::MODE_STR, sxt_pkg::MODE_ESC,
                                  sxt_pkg::MODE_HEX1, sxt_pkg::MODE_HEX2}) begin
        v0 = 1'b1;
        r0 = make_res(sxt_pkg::KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b1);
      end
    end else begin
      case (mode_q)
        sxt_pkg::MODE_SYM: begin
          if (is_graphic(b) && !is_breaker(b)) begin
            v0 = 1'b1;
            r0 = make_res(sxt_pkg::KIND_SYMBOL, b, 1'b1, 1'b0, 1'b0);
          end else begin
            // close the symbol, then treat the byte as if idle
            v0     = 1'b1;
            r0     = make_res(sxt_pkg::KIND_SYMBOL, 8'd0, 1'b0, 1'b0, 1'b1);
            v1     = idle_v;
            r1     = idle_r;
            mode_d = idle_m;
          end
        end
        sxt_pkg::MODE_STR: begin
          if (b == sxt_pkg::CH_BSLASH) begin
            mode_d = sxt_pkg::MODE_ESC;
          end else if (b == sxt_pkg::CH_DQUOTE) begin
            mode_d = sxt_pkg::MODE_IDLE;
            v0     = 1'b1;
            r0     = make_res(sxt_pkg::KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b1);
          end else begin
            v0 = 1'b1;
            r0 = make_res(sxt_pkg::KIND_STRING, b, 1'b1, 1'b0, 1'b0);
          end
        end
        sxt_pkg::MODE_ESC: begin
          if (b == sxt_pkg::CH_LOW_X) begin
            hex_d  = 8'd0;
            mode_d = sxt_pkg::MODE_HEX1;
          end else begin
            mode_d = sxt_pkg::MODE_STR;
            v0     = 1'b1;
            r0     = make_res(sxt_pkg::KIND_STRING, unescape(b), 1'b1, 1'b0, 1'b0);
          end
        end
        sxt_pkg::MODE_HEX1: begin
          hex_d  = hex_val(b);
          mode_d = sxt_pkg::MODE_HEX2;
        end
        sxt_pkg::MODE_HEX2: begin
          // only the low nibble of the first digit survives the 8-bit truncation
          v0     = 1'b1;
          r0     = make_res(sxt_pkg::KIND_STRING, {hex_q[3:0], 4'd0} + hex_val(b),
                            1'b1, 1'b0, 1'b0);
          hex_d  = 8'd0;
          mode_d = sxt_pkg::MODE_STR;
        end
        default: begin
          mode_d = idle_m;
          v0     = idle_v;
          r0     = idle_r;
        end
      endcase
    end

    // flag the final result of this byte
    if (v1) begin
      r1.last_of_run = 1'b1;
    end else begin
      r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sxt_pkg::MODE_IDLE;
      hex_q  <= 8'd0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  sxt_pkg::result_t fifo_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    count_q;
  logic [PtrW-1:0]  wptr_nxt;
  logic             wr0, wr1, pop;
  logic [1:0]       n_wr;
  sxt_pkg::result_t head;

  assign wr0      = in_acc & v0;
  assign wr1      = in_acc & v1;
  assign n_wr     = {1'b0, wr0} + {1'b0, wr1};
  assign wptr_nxt = wptr_q + PtrW'(1);
  assign pop      = out_o.valid & out_o.ready;

  // take a byte only while room remains for its worst case of two results
  assign in_i.ready = (count_q <= (PtrW+1)'(Depth - 2));

  always_ff @(posedge clk_i) begin
    if (wr0) begin
      fifo_q[wptr_q] <= r0;
    end
    if (wr1) begin
      fifo_q[wptr_nxt] <= r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PtrW'(n_wr);
      if (pop) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      count_q <= count_q + (PtrW+1)'(n_wr) - (PtrW+1)'(pop);
    end
  end

  assign head              = fifo_q[rptr_q];
  assign out_o.valid       = (count_q != '0);
  assign out_o.token_kind  = head.kind;
  assign out_o.char_value  = head.char_value;
  assign out_o.has_char    = head.has_char;
  assign out_o.token_start = head.token_start;
  assign out_o.token_end   = head.token_end;
  assign out_o.last_of_run = head.last_of_run;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(Depth))
    else $error("result queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != (PtrW+1)'(Depth)) |-> (count_q[PtrW-1:0] == PtrW'(wptr_q - rptr_q)))
    else $error("queue pointers disagree with count");

  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && eoi) |=> (mode_q == sxt_pkg::MODE_IDLE && hex_q == 8'd0))
    else $error("end of input did not return the lexer to idle");

  a_run_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_of_run) |-> (count_q >= (PtrW+1)'(2)))
    else $error("result run split without its final entry queued");

endmodule
